// ===== rtl/core/lgs_pkg.sv =====
// Shared types and constants for the Laplace grid Gauss-Seidel unit.
// Holds the beat payload structs, the register map, the controller states and
// the command and status bundles; it depends on nothing else.
package lgs_pkg;

    // Field widths fixed by the interface.
    localparam int VAL_W     = 24;
    localparam int SUM_W     = VAL_W + 2;
    localparam int STEP_W    = 5;
    localparam int IDX_W     = 5;
    localparam int CNT_W     = 16;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 3;

    // Default largest side of the grid in points.
    localparam int DEF_MAX_SIDE = 32;

    // Register values after reset.
    localparam logic [VAL_W-1:0]  RST_LEFT   = VAL_W'(19200);
    localparam logic [VAL_W-1:0]  RST_RIGHT  = VAL_W'(12800);
    localparam logic [VAL_W-1:0]  RST_TOP    = VAL_W'(25600);
    localparam logic [VAL_W-1:0]  RST_BOTTOM = VAL_W'(0);
    localparam logic [STEP_W-1:0] RST_STEPS  = STEP_W'(10);
    localparam logic [CNT_W-1:0]  RST_SWEEPS = CNT_W'(100);

    // Register map of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT    = 3'd0,
        REG_RIGHT   = 3'd1,
        REG_TOP     = 3'd2,
        REG_BOTTOM  = 3'd3,
        REG_STEPS_X = 3'd4,
        REG_STEPS_Y = 3'd5,
        REG_SWEEPS  = 3'd6
    } t_reg_idx;

    // Request kinds.
    typedef enum logic {
        REQ_SOLVE = 1'b0,
        REQ_READ  = 1'b1
    } t_req;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_UNSOLVED = 2'd2
    } t_status;

    // Neighbor selection for the stencil reads.
    typedef enum logic [1:0] {
        NB_W = 2'd0,
        NB_E = 2'd1,
        NB_S = 2'd2,
        NB_N = 2'd3
    } t_nbr;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE   = 4'd0,
        S_FILL   = 4'd1,
        S_RD_W   = 4'd2,
        S_RD_E   = 4'd3,
        S_RD_S   = 4'd4,
        S_RD_N   = 4'd5,
        S_WR     = 4'd6,
        S_LOOKUP = 4'd7,
        S_DONE   = 4'd8
    } t_state;

    // Input beat payload.
    typedef struct packed {
        logic              req_type;
        logic [IDX_W-1:0]  x_index;
        logic [IDX_W-1:0]  y_index;
    } t_in_item;

    // Output beat payload.
    typedef struct packed {
        logic [VAL_W-1:0]  point_value;
        logic [STAT_W-1:0] status;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // capture the request fields
        logic solve_init;  // latch grid sizes, clear the point counters
        logic fill_wr;     // write one edge or start value, advance
        logic sweep_init;  // point counters to the first interior point
        logic rd_en;       // read one neighbor
        t_nbr nbr_sel;
        logic acc_first;   // load the sum with the returned neighbor
        logic acc_add;     // add the returned neighbor to the sum
        logic pt_wr;       // write the averaged point, advance
        logic lookup;      // read the requested point
        logic out_load;    // load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_is_read;
        logic fill_last;
        logic has_work;
        logic pt_last;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/core/lgs_ctrl.sv =====
// Controller of the Laplace grid unit: sequences fill, sweeps and point reads.
// Uses lgs_pkg; drives the datapath only through the command bundle.
module lgs_ctrl
    import lgs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.in_is_read) begin
                        n_state = S_LOOKUP;
                    end else begin
                        o_cmd.solve_init = 1'b1;
                        n_state          = S_FILL;
                    end
                end
            end
            S_FILL: begin
                o_cmd.fill_wr = 1'b1;
                if (i_stat.fill_last) begin
                    if (i_stat.has_work) begin
                        o_cmd.sweep_init = 1'b1;
                        n_state          = S_RD_W;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RD_W: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.nbr_sel = NB_W;
                n_state       = S_RD_E;
            end
            S_RD_E: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.nbr_sel   = NB_E;
                o_cmd.acc_first = 1'b1;
                n_state         = S_RD_S;
            end
            S_RD_S: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.nbr_sel = NB_S;
                o_cmd.acc_add = 1'b1;
                n_state       = S_RD_N;
            end
            S_RD_N: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.nbr_sel = NB_N;
                o_cmd.acc_add = 1'b1;
                n_state       = S_WR;
            end
            S_WR: begin
                o_cmd.pt_wr = 1'b1;
                if (i_stat.pt_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD_W;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                // Wait until the result register can take the beat.
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/lgs_dpath.sv =====
// Datapath of the Laplace grid unit: registers, point counters, grid memory,
// stencil sum and result register. Uses lgs_pkg; commanded by lgs_ctrl.
module lgs_dpath
    import lgs_pkg::*;
#(
    parameter int MAX_SIDE = DEF_MAX_SIDE
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_in_item             i_in_data,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [VAL_W-1:0]     i_cfg_data,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output t_out_item            o_out_data,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat
);

    localparam int CW    = $clog2(MAX_SIDE);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = (SW > STEP_W + 1) ? SW : STEP_W + 1;
    localparam int ZW    = (SW > IDX_W) ? SW : IDX_W;

    // Configuration registers.
    logic [VAL_W-1:0]  r_left, r_right, r_top, r_bottom;
    logic [STEP_W-1:0] r_steps_x, r_steps_y;
    logic [CNT_W-1:0]  r_sweeps;

    // Grid sizes of the last solve and solve status.
    logic [SW-1:0] r_side_x, r_side_y;
    logic [CW-1:0] r_xl, r_yl, r_xi, r_yi;
    logic          r_interior;
    logic          r_solved;

    // Request capture, point counters and stencil sum.
    logic             r_req;
    logic [IDX_W-1:0] r_xq, r_yq;
    logic [CW-1:0]    r_x, r_y;
    logic [CW-1:0]    n_x, n_y;
    logic [CNT_W-1:0] r_k, n_k;
    logic [SUM_W-1:0] r_sum;

    // Grid memory and its registered read data.
    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rd_data;

    // Result register.
    logic      r_out_vld;
    t_out_item r_out_data;

    logic [SW-1:0]    n_side_x, n_side_y;
    logic [CW-1:0]    rd_x, rd_y;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic             mem_we, mem_re;
    logic [VAL_W-1:0] fill_val, wr_data;
    logic [SUM_W-1:0] full_sum;
    logic             in_range;
    t_out_item        res;

    // Side length in points, saturated to the grid store.
    function automatic logic [SW-1:0] side_of(input logic [STEP_W-1:0] steps);
        logic [PW-1:0] p;
        p = PW'(steps) + PW'(1);
        if (p > PW'(MAX_SIDE)) begin
            side_of = SW'(MAX_SIDE);
        end else begin
            side_of = SW'(p);
        end
    endfunction

    // Address of a point, x major.
    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] cx,
                                              input logic [CW-1:0] cy);
        addr_of = AW'(AW'(cx) * AW'(MAX_SIDE) + AW'(cy));
    endfunction

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= RST_LEFT;
            r_right   <= RST_RIGHT;
            r_top     <= RST_TOP;
            r_bottom  <= RST_BOTTOM;
            r_steps_x <= RST_STEPS;
            r_steps_y <= RST_STEPS;
            r_sweeps  <= RST_SWEEPS;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_index))
                REG_LEFT:    r_left    <= i_cfg_data;
                REG_RIGHT:   r_right   <= i_cfg_data;
                REG_TOP:     r_top     <= i_cfg_data;
                REG_BOTTOM:  r_bottom  <= i_cfg_data;
                REG_STEPS_X: r_steps_x <= i_cfg_data[STEP_W-1:0];
                REG_STEPS_Y: r_steps_y <= i_cfg_data[STEP_W-1:0];
                REG_SWEEPS:  r_sweeps  <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign n_side_x = side_of(r_steps_x);
    assign n_side_y = side_of(r_steps_y);

    // Grid sizes are latched when a solve starts; the solved flag is set with
    // its result beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_x <= '0;
            r_side_y <= '0;
            r_solved <= 1'b0;
        end else begin
            if (i_cmd.solve_init) begin
                r_side_x <= n_side_x;
                r_side_y <= n_side_y;
            end
            if (i_cmd.out_load && (r_req == REQ_SOLVE)) begin
                r_solved <= 1'b1;
            end
        end
    end

    // Derived loop bounds of the current solve.
    always_ff @(posedge i_clk) begin
        if (i_cmd.solve_init) begin
            r_xl       <= CW'(n_side_x - SW'(1));
            r_yl       <= CW'(n_side_y - SW'(1));
            r_xi       <= CW'(n_side_x - SW'(2));
            r_yi       <= CW'(n_side_y - SW'(2));
            r_interior <= (n_side_x >= SW'(3)) && (n_side_y >= SW'(3));
        end
    end

    // Request fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_in_data.req_type;
            r_xq  <= i_in_data.x_index;
            r_yq  <= i_in_data.y_index;
        end
    end

    // Point counters: the fill walks every point, a sweep the interior points,
    // both with y inner.
    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_k = r_k;
        if (i_cmd.solve_init) begin
            n_x = '0;
            n_y = '0;
        end
        if (i_cmd.fill_wr) begin
            if (r_y == r_yl) begin
                n_y = '0;
                n_x = r_x + CW'(1);
            end else begin
                n_y = r_y + CW'(1);
            end
        end
        if (i_cmd.sweep_init) begin
            n_x = CW'(1);
            n_y = CW'(1);
            n_k = '0;
        end
        if (i_cmd.pt_wr) begin
            if (r_y == r_yi) begin
                n_y = CW'(1);
                if (r_x == r_xi) begin
                    n_x = CW'(1);
                    n_k = r_k + CNT_W'(1);
                end else begin
                    n_x = r_x + CW'(1);
                end
            end else begin
                n_y = r_y + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_k <= n_k;
    end

    // Edge priority: right, left, top, bottom; interior starts at the top value.
    always_comb begin
        if (r_x == r_xl) begin
            fill_val = r_right;
        end else if (r_x == '0) begin
            fill_val = r_left;
        end else if (r_y == r_yl) begin
            fill_val = r_top;
        end else if (r_y == '0) begin
            fill_val = r_bottom;
        end else begin
            fill_val = r_top;
        end
    end

    // Neighbor coordinates for the stencil reads.
    always_comb begin
        rd_x = r_x;
        rd_y = r_y;
        case (i_cmd.nbr_sel)
            NB_W:    rd_x = r_x - CW'(1);
            NB_E:    rd_x = r_x + CW'(1);
            NB_S:    rd_y = r_y - CW'(1);
            NB_N:    rd_y = r_y + CW'(1);
            default: rd_x = r_x;
        endcase
    end

    // The requested point lies inside the last solved grid.
    assign in_range = (ZW'(r_xq) < ZW'(r_side_x)) && (ZW'(r_yq) < ZW'(r_side_y));

    // Memory ports; a lookup reads only a point that lies inside the grid.
    assign full_sum = r_sum + SUM_W'(r_rd_data);
    assign mem_we   = i_cmd.fill_wr || i_cmd.pt_wr;
    assign wr_data  = i_cmd.pt_wr ? full_sum[SUM_W-1:2] : fill_val;
    assign wr_addr  = addr_of(r_x, r_y);
    assign mem_re   = i_cmd.rd_en || (i_cmd.lookup && r_solved && in_range);
    assign rd_addr  = i_cmd.lookup ? addr_of(CW'(r_xq), CW'(r_yq)) : addr_of(rd_x, rd_y);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Stencil sum of the first three neighbors; the fourth joins at the write.
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_first) begin
            r_sum <= SUM_W'(r_rd_data);
        end else if (i_cmd.acc_add) begin
            r_sum <= full_sum;
        end
    end

    // Result of the current request.
    always_comb begin
        res.point_value = '0;
        res.status      = ST_OK;
        if (r_req == REQ_READ) begin
            if (!r_solved) begin
                res.status = ST_UNSOLVED;
            end else if (!in_range) begin
                res.status = ST_RANGE;
            end else begin
                res.point_value = r_rd_data;
            end
        end
    end

    // Result register; a new beat may load while the old one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    // Status to the controller.
    assign o_stat.in_is_read = (i_in_data.req_type == REQ_READ);
    assign o_stat.fill_last  = (r_x == r_xl) && (r_y == r_yl);
    assign o_stat.has_work   = r_interior && (r_sweeps != '0);
    assign o_stat.pt_last    = (r_x == r_xi) && (r_y == r_yi) &&
                               (r_k == r_sweeps - CNT_W'(1));
    assign o_stat.out_free   = !r_out_vld || !i_out_stall;

endmodule

// ===== rtl/core/laplace_grid_gauss_seidel_unit.sv =====
// Laplace grid Gauss-Seidel unit: solves a five-point Laplace stencil in place.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) carries one request per
// beat: a solve of the whole grid, or a read of one point. Output channel
// (o_out_valid / i_out_stall / o_out_data) returns exactly one beat for each
// request: the point value and a status (ok, index out of range, not solved).
// Config port: one register per cycle at i_cfg_index while i_cfg_wr_en is high.
// The user must write it only while the unit is idle; the unit does not check.
//
// Requests are handled one at a time. A solve runs to its result beat as one
// memory write per point for the fill, then, in each sweep, four neighbor
// reads and one write per interior point on the single read port of the grid
// memory. The next request is taken while a result still waits.
//
// Synchronous reset restores the registers, clears the solved flag and the
// handshakes; the grid memory is not cleared and is never read before a solve.
// While the receiver stalls, the result beat holds and the unit stops in its
// final state until the result register frees up.
module laplace_grid_gauss_seidel_unit
    import lgs_pkg::*;
#(
    parameter int MAX_SIDE = DEF_MAX_SIDE
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [VAL_W-1:0]     i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer.
    lgs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Grid memory and arithmetic.
    lgs_dpath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule
